### hw/rtl/ifrd_pkg.sv
package ifrd_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] EscByte = 8'h7d;
  localparam logic [7:0] EscFlag = 8'h5e;
  localparam logic [7:0] EscEsc  = 8'h5d;

  localparam logic [7:0] FlagByteReset        = 8'h7e;
  localparam logic [7:0] FrameAddressReset    = 8'h03;
  localparam logic [7:0] ExpectedControlReset = 8'h00;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_FLAG_BYTE        = 2'd0,
    CFG_FRAME_ADDRESS    = 2'd1,
    CFG_EXPECTED_CONTROL = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BCC2    = 2'd1,
    ST_BAD_ESC = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_payload_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    status_t    status;
  } res_payload_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_END  = 1'b1
  } op_kind_t;

  // One classified operation from the parser to the back end.
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
    logic       bad_escape;
  } op_t;

endpackage

### hw/rtl/ifrd_stream_if.sv
interface ifrd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/ifrd_front.sv
module ifrd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ifrd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [ifrd_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic                               in_accept,
  input  logic [7:0]                         in_byte,
  output logic                               op_valid,
  output ifrd_pkg::op_t                      op
);
  import ifrd_pkg::*;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_ADDR = 5'b00010,
    PH_CTRL = 5'b00100,
    PH_HCHK = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  logic [7:0] flag_byte;
  logic [7:0] frame_address;
  logic [7:0] expected_control;

  phase_t phase, phase_next;
  logic   esc_pending, esc_pending_next;
  logic   esc_error, esc_error_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte        <= FlagByteReset;
      frame_address    <= FrameAddressReset;
      expected_control <= ExpectedControlReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLAG_BYTE:        flag_byte        <= cfg_data;
        CFG_FRAME_ADDRESS:    frame_address    <= cfg_data;
        CFG_EXPECTED_CONTROL: expected_control <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next       = phase;
    esc_pending_next = esc_pending;
    esc_error_next   = esc_error;
    op_valid         = 1'b0;
    op.kind          = OP_PUSH;
    op.value         = in_byte;
    op.bad_escape    = esc_error | esc_pending;
    if (in_accept) begin
      unique case (phase)
        PH_ADDR: begin
          if (in_byte == frame_address) phase_next = PH_CTRL;
          else if (in_byte == flag_byte) phase_next = PH_ADDR;
          else phase_next = PH_HUNT;
        end
        PH_CTRL: begin
          if (in_byte == expected_control) phase_next = PH_HCHK;
          else if (in_byte == flag_byte) phase_next = PH_ADDR;
          else phase_next = PH_HUNT;
        end
        PH_HCHK: begin
          if (in_byte == (frame_address ^ expected_control)) begin
            phase_next       = PH_DATA;
            esc_pending_next = 1'b0;
            esc_error_next   = 1'b0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (in_byte == flag_byte) begin
            op_valid         = 1'b1;
            op.kind          = OP_END;
            phase_next       = PH_HUNT;
            esc_pending_next = 1'b0;
            esc_error_next   = 1'b0;
          end else if (esc_pending && in_byte == EscFlag) begin
            op_valid         = 1'b1;
            op.value         = flag_byte;
            esc_pending_next = 1'b0;
          end else if (esc_pending && in_byte == EscEsc) begin
            op_valid         = 1'b1;
            op.value         = EscByte;
            esc_pending_next = 1'b0;
          end else begin
            // bad escape drops the escape, byte handled as plain payload
            if (esc_pending) esc_error_next = 1'b1;
            if (in_byte == EscByte) begin
              esc_pending_next = 1'b1;
            end else begin
              esc_pending_next = 1'b0;
              op_valid         = 1'b1;
            end
          end
        end
        default: begin
          if (in_byte == flag_byte) phase_next = PH_ADDR;
          else phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      esc_pending <= 1'b0;
      esc_error   <= 1'b0;
    end else begin
      phase       <= phase_next;
      esc_pending <= esc_pending_next;
      esc_error   <= esc_error_next;
    end
  end

endmodule

### hw/rtl/ifrd_queue.sv
module ifrd_queue #(
  parameter int unsigned Depth = ifrd_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ifrd_pkg::op_t push_op,
  output logic          not_full,
  input  logic          pop,
  output logic          head_valid,
  output ifrd_pkg::op_t head_op
);
  import ifrd_pkg::*;

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  op_t                entries [Depth];
  logic [PtrWidth-1:0] wr_ptr, rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push, do_pop;

  assign not_full   = (count != FullCnt);
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/ifrd_back.sv
module ifrd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   op_valid,
  input  ifrd_pkg::op_t          op,
  output logic                   op_pop,
  output logic                   res_valid,
  input  logic                   res_ready,
  output ifrd_pkg::res_payload_t res_data
);
  import ifrd_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic [7:0] running_xor;
  status_t    end_status;

  assign op_pop = op_valid && (!res_valid || res_ready);

  always_comb begin
    if (op.bad_escape) end_status = ST_BAD_ESC;
    else if (!held_valid) end_status = ST_EMPTY;
    else if (held_byte != running_xor) end_status = ST_BCC2;
    else end_status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      held_valid  <= 1'b0;
      held_byte   <= '0;
      running_xor <= '0;
    end else begin
      if (res_ready) res_valid <= 1'b0;
      if (op_pop) begin
        unique case (op.kind)
          OP_END: begin
            res_valid          <= 1'b1;
            res_data.data_byte <= '0;
            res_data.frame_end <= 1'b1;
            res_data.status    <= end_status;
            held_valid         <= 1'b0;
            held_byte          <= '0;
            running_xor        <= '0;
          end
          OP_PUSH: begin
            // newest byte is held back; the previous one goes out
            if (held_valid) begin
              res_valid          <= 1'b1;
              res_data.data_byte <= held_byte;
              res_data.frame_end <= 1'b0;
              res_data.status    <= ST_OK;
              running_xor        <= running_xor ^ held_byte;
            end
            held_byte  <= op.value;
            held_valid <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### hw/rtl/info_frame_receiver_destuffer.sv
// Path: accepted bytes pass the front parser into an op queue of QueueDepth entries;
//   the back end pops each op and loads its result (if any) into the output register.
// Throughput: one byte per cycle while the op queue is not full; front parser and back
//   emitter each take one transaction per cycle, the emitter only while res is not stalled.
// Reset: synchronous, active high; clears the parse phase, escape state, queue,
//   held byte, running XOR and output valid, and loads the register defaults.
module info_frame_receiver_destuffer #(
  parameter int unsigned QueueDepth = ifrd_pkg::QueueDepthDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  ifrd_stream_if.sink                        rx,
  ifrd_stream_if.source                      res,
  input  logic                               cfg_we,
  input  logic [ifrd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [ifrd_pkg::CfgDataWidth-1:0]  cfg_data
);
  import ifrd_pkg::*;

  // Front: header hunt/check and destuffing, one op per payload byte or closing flag.
  logic in_accept;
  logic front_op_valid;
  op_t  front_op;

  // Queue head toward the back end.
  logic q_not_full;
  logic q_head_valid;
  op_t  q_head_op;
  logic q_pop;

  res_payload_t res_payload;

  // Input stalls only when the op queue is full.
  assign rx.ready  = q_not_full;
  assign in_accept = rx.valid && rx.ready;

  ifrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_byte   (rx.data.rx_byte),
    .op_valid  (front_op_valid),
    .op        (front_op)
  );

  ifrd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_op_valid),
    .push_op    (front_op),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  // Back: held byte, running XOR and BCC2 check; registered result output.
  ifrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_head_valid),
    .op        (q_head_op),
    .op_pop    (q_pop),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res_payload)
  );

  assign res.data = res_payload;

endmodule

### hw/rtl/ifrd_checker.sv
module ifrd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] data_byte,
  input logic       frame_end,
  input logic [1:0] status
);
  import ifrd_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable({data_byte, frame_end, status}))
    else $error("result changed while stalled");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_end |-> data_byte == 8'd0)
    else $error("end result with nonzero data");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && !frame_end |-> status == ST_OK)
    else $error("data result with nonzero status");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind info_frame_receiver_destuffer ifrd_checker u_ifrd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .data_byte (res.data.data_byte),
  .frame_end (res.data.frame_end),
  .status    (res.data.status)
);
